>>> hdl/log_bin_spectrum_redshift_rebin_macros.svh
// assertion macros used by the checker file
// needs clk and rst_n in the scope where a macro is used
`ifndef LOG_BIN_SPECTRUM_REDSHIFT_REBIN_MACROS_SVH
`define LOG_BIN_SPECTRUM_REDSHIFT_REBIN_MACROS_SVH

// same-cycle implication
`define LBRR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbrr check failed");

// next-cycle implication
`define LBRR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbrr check failed");

`endif

>>> hdl/lbrr_pkg.sv
// shared types and constants for the redshift rebin block
// no dependencies
package lbrr_pkg;

    localparam int MAX_BINS_DEF = 64;

    localparam int EW  = 40;   // energy, Q32.8
    localparam int FW  = 48;   // flux, Q24.24
    localparam int SW  = 17;   // scale factor, Q1.16
    localparam int HW  = 18;   // half bin factor, Q2.16
    localparam int LW  = 48;   // lower edge, Q.16
    localparam int UW  = 50;   // upper edge, Q.16
    localparam int ZW  = 51;   // compare width for edges
    localparam int PW  = UW + FW;  // overlap times flux
    localparam int QW  = 48;   // quotient width
    localparam int OIW = 6;    // output bin index

    localparam logic [HW-1:0] H_ONE     = 18'd65536;
    localparam logic [SW-1:0] S_RESET   = 17'd65536;
    localparam logic [HW-1:0] H_RESET   = 18'd73533;
    localparam logic [FW-1:0] FLUX_MAX  = {FW{1'b1}};

    localparam logic REG_SCALE = 1'b0;
    localparam logic REG_HALF  = 1'b1;

    typedef struct packed {
        logic          start;
        logic [UW-1:0] rem;
        logic [QW-1:0] low;
        logic [UW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] quot;
    } div_rsp_t;

endpackage

>>> hdl/lbrr_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module lbrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/lbrr_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on lbrr_pkg; quotient must fit in QW bits
module lbrr_div
    import lbrr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNW = $clog2(QW);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic [ZW-1:0]  rem_reg, rem_next;
    logic [QW-1:0]  low_reg, low_next;
    logic [UW-1:0]  d_reg, d_next;
    logic [QW-1:0]  q_reg, q_next;
    logic [ZW-1:0]  trial;
    logic           fits;

    assign trial = {rem_reg[UW-1:0], low_reg[QW-1]};
    assign fits  = trial >= ZW'(d_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = ZW'(req.rem);
            low_next  = req.low;
            d_next    = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial - ZW'(d_reg) : trial;
            low_next = {low_reg[QW-2:0], 1'b0};
            q_next   = {q_reg[QW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNW'(QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule

>>> hdl/log_bin_spectrum_redshift_rebin.sv
// Redshift rebin of a log-spaced spectrum. Bins stream in at one beat per cycle
// and are stored in on-chip ram; the beat with tlast starts the compute and the
// input stalls until the last result has been handed to the output register.
// The compute first derives the edges of every stored bin with the shared 48-step
// divider, then for each bin m walks bins m..count-1: a bin with no overlap or full
// containment goes straight to the accumulate step, and a partial overlap first runs
// the split multiply and then the 48-step divider.
// depends on lbrr_pkg, lbrr_ram, lbrr_div
module log_bin_spectrum_redshift_rebin
    import lbrr_pkg::*;
#(
    parameter int MAX_BINS = MAX_BINS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // tdata: bin_energy[39:0], bin_flux[87:40]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic        s_tlast,
    // tdata: bin_index[5:0], shifted_flux[53:6], zero pad[55:54]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = $clog2(MAX_BINS);
    localparam int CW = $clog2(MAX_BINS + 1);

    typedef enum logic [12:0] {
        ST_LOAD  = 13'b0000000000001,
        ST_E_RD  = 13'b0000000000010,
        ST_E_MUL = 13'b0000000000100,
        ST_E_DIV = 13'b0000000001000,
        ST_M_RD  = 13'b0000000010000,
        ST_M_SCL = 13'b0000000100000,
        ST_N_RD  = 13'b0000001000000,
        ST_N_CMP = 13'b0000010000000,
        ST_N_SEL = 13'b0000100000000,
        ST_N_MUL = 13'b0001000000000,
        ST_N_DIV = 13'b0010000000000,
        ST_N_ACC = 13'b0100000000000,
        ST_EMIT  = 13'b1000000000000
    } state_t;

    state_t         state_reg, state_next;
    logic [SW-1:0]  scale_reg, scale_next;
    logic [HW-1:0]  half_reg, half_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  total_reg, total_next;
    logic [IW-1:0]  i_reg, i_next;
    logic [IW-1:0]  m_reg, m_next;
    logic [IW-1:0]  n_reg, n_next;
    logic [UW-1:0]  up_reg, up_next;
    logic [ZW-1:0]  lz_reg, lz_next;
    logic [ZW-1:0]  uz_reg, uz_next;
    logic [ZW-1:0]  ln_reg, ln_next;
    logic [ZW-1:0]  un_reg, un_next;
    logic [FW-1:0]  f_reg, f_next;
    logic [5:0]     flag_reg, flag_next;
    logic [UW-1:0]  num_reg, num_next;
    logic [UW-1:0]  w_reg, w_next;
    logic [PW-1:0]  prod_reg, prod_next;
    logic [1:0]     k_reg, k_next;
    logic [FW-1:0]  add_reg, add_next;
    logic [FW-1:0]  sum_reg, sum_next;
    logic           ov_reg, ov_next;
    logic [OIW-1:0] oidx_reg, oidx_next;
    logic [FW-1:0]  oflux_reg, oflux_next;
    logic           olast_reg, olast_next;

    logic           e_we, f_we, g_we;
    logic [IW-1:0]  e_raddr, g_raddr;
    logic [EW-1:0]  e_rdata;
    logic [FW-1:0]  f_rdata;
    logic [UW+LW-1:0] g_rdata;
    logic [HW-1:0]  h_eff;
    div_req_t       div_req;
    div_rsp_t       div_rsp;
    logic           cfg_wr;
    logic           s_acc;
    logic           m_free;
    logic [CW-1:0]  cnt_inc;
    logic [UW-1:0]  g_un;
    logic [LW-1:0]  g_ln;
    logic [24:0]    mul_a;
    logic [23:0]    mul_b;
    logic [48:0]    pp;
    logic [FW:0]    sum_wide;
    logic           n_last, m_last, i_last;
    logic           c1, c2, c3, c4;

    lbrr_ram #(.WIDTH(EW), .DEPTH(MAX_BINS)) u_energy_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (cnt_reg[IW-1:0]),
        .wdata (s_tdata[EW-1:0]),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    lbrr_ram #(.WIDTH(FW), .DEPTH(MAX_BINS)) u_flux_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (cnt_reg[IW-1:0]),
        .wdata (s_tdata[EW+FW-1:EW]),
        .raddr (n_reg),
        .rdata (f_rdata)
    );

    lbrr_ram #(.WIDTH(UW+LW), .DEPTH(MAX_BINS)) u_edge_ram (
        .clk   (clk),
        .we    (g_we),
        .waddr (i_reg),
        .wdata ({up_reg, div_rsp.quot}),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    lbrr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign s_tready = (state_reg == ST_LOAD);
    assign s_acc    = s_tvalid & s_tready;
    assign m_free   = !ov_reg | m_tready;
    assign m_tvalid = ov_reg;
    assign m_tdata  = {2'b00, oflux_reg, oidx_reg};
    assign m_tlast  = olast_reg;

    always_comb
    begin
        unique case (paddr[2])
            REG_SCALE: prdata = 32'(scale_reg);
            REG_HALF:  prdata = 32'(half_reg);
            default:   prdata = '0;
        endcase
    end

    assign h_eff   = (half_reg < H_ONE) ? H_ONE : half_reg;
    assign e_we    = s_acc && (cnt_reg < CW'(MAX_BINS));
    assign f_we    = e_we;
    assign cnt_inc = e_we ? cnt_reg + 1'b1 : cnt_reg;
    assign e_raddr = i_reg;
    assign g_raddr = (state_reg == ST_M_RD) ? m_reg : n_reg;
    assign g_we    = (state_reg == ST_E_DIV) && div_rsp.done;
    assign g_un    = g_rdata[UW+LW-1:LW];
    assign g_ln    = g_rdata[LW-1:0];
    assign i_last  = (CW'(i_reg) == total_reg - 1'b1);
    assign m_last  = (CW'(m_reg) == total_reg - 1'b1);
    assign n_last  = (CW'(n_reg) == total_reg - 1'b1);

    // flags: ln<=lz, uz<=un, lz<un, un<=uz, lz<=ln, ln<=uz
    assign c1 = flag_reg[0] & flag_reg[1];
    assign c2 = flag_reg[0] & flag_reg[2] & flag_reg[3];
    assign c3 = flag_reg[4] & flag_reg[5] & flag_reg[1];
    assign c4 = flag_reg[4] & flag_reg[3];

    assign mul_a    = k_reg[1] ? num_reg[UW-1:25] : num_reg[24:0];
    assign mul_b    = k_reg[0] ? f_reg[FW-1:24] : f_reg[23:0];
    assign pp       = 49'(mul_a) * 49'(mul_b);
    assign sum_wide = (FW+1)'(sum_reg) + (FW+1)'(add_reg);

    always_comb
    begin
        state_next = state_reg;
        scale_next = scale_reg;
        half_next  = half_reg;
        cnt_next   = cnt_reg;
        total_next = total_reg;
        i_next     = i_reg;
        m_next     = m_reg;
        n_next     = n_reg;
        up_next    = up_reg;
        lz_next    = lz_reg;
        uz_next    = uz_reg;
        ln_next    = ln_reg;
        un_next    = un_reg;
        f_next     = f_reg;
        flag_next  = flag_reg;
        num_next   = num_reg;
        w_next     = w_reg;
        prod_next  = prod_reg;
        k_next     = k_reg;
        add_next   = add_reg;
        sum_next   = sum_reg;
        ov_next    = ov_reg & !m_tready;
        oidx_next  = oidx_reg;
        oflux_next = oflux_reg;
        olast_next = olast_reg;
        div_req    = '0;

        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_SCALE: scale_next = pwdata[SW-1:0];
                REG_HALF:  half_next  = pwdata[HW-1:0];
                default:   scale_next = scale_reg;
            endcase
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_acc)
                begin
                    cnt_next = cnt_inc;
                    if (s_tlast)
                    begin
                        total_next = cnt_inc;
                        i_next     = '0;
                        state_next = ST_E_RD;
                    end
                end
            end
            ST_E_RD:
            begin
                state_next = ST_E_MUL;
            end
            ST_E_MUL:
            begin
                up_next         = UW'((58'(e_rdata) * 58'(h_eff)) >> 8);
                div_req.start   = 1'b1;
                div_req.rem     = UW'(e_rdata[EW-1:24]);
                div_req.low     = {e_rdata[23:0], 24'd0};
                div_req.divisor = UW'(h_eff);
                state_next      = ST_E_DIV;
            end
            ST_E_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (i_last)
                    begin
                        m_next     = '0;
                        state_next = ST_M_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_E_RD;
                    end
                end
            end
            ST_M_RD:
            begin
                state_next = ST_M_SCL;
            end
            ST_M_SCL:
            begin
                lz_next    = ZW'((65'(g_ln) * 65'(scale_reg)) >> 16);
                uz_next    = ZW'((67'(g_un) * 67'(scale_reg)) >> 16);
                sum_next   = '0;
                n_next     = m_reg;
                state_next = ST_N_RD;
            end
            ST_N_RD:
            begin
                state_next = ST_N_CMP;
            end
            ST_N_CMP:
            begin
                ln_next      = ZW'(g_ln);
                un_next      = ZW'(g_un);
                f_next       = f_rdata;
                flag_next[0] = ZW'(g_ln) <= lz_reg;
                flag_next[1] = uz_reg <= ZW'(g_un);
                flag_next[2] = lz_reg < ZW'(g_un);
                flag_next[3] = ZW'(g_un) <= uz_reg;
                flag_next[4] = lz_reg <= ZW'(g_ln);
                flag_next[5] = ZW'(g_ln) <= uz_reg;
                state_next   = ST_N_SEL;
            end
            ST_N_SEL:
            begin
                w_next    = UW'(un_reg - ln_reg);
                prod_next = '0;
                k_next    = '0;
                add_next  = '0;
                priority if (c1)
                begin
                    num_next = UW'(uz_reg - lz_reg);
                end
                else if (c2)
                begin
                    num_next = UW'(un_reg - lz_reg);
                end
                else if (c3)
                begin
                    num_next = UW'(uz_reg - ln_reg);
                end
                else
                begin
                    num_next = '0;
                end
                if ((c1 | c2 | c3) && (un_reg != ln_reg))
                begin
                    state_next = ST_N_MUL;
                end
                else
                begin
                    if (!(c1 | c2 | c3) && c4)
                    begin
                        add_next = f_reg;
                    end
                    state_next = ST_N_ACC;
                end
            end
            ST_N_MUL:
            begin
                unique case (k_reg)
                    2'd0: prod_next = prod_reg + PW'(pp);
                    2'd1: prod_next = prod_reg + (PW'(pp) << 24);
                    2'd2: prod_next = prod_reg + (PW'(pp) << 25);
                    2'd3: prod_next = prod_reg + (PW'(pp) << 49);
                    default: prod_next = prod_reg;
                endcase
                k_next = k_reg + 1'b1;
                if (k_reg == 2'd3)
                begin
                    state_next = ST_N_DIV;
                end
            end
            ST_N_DIV:
            begin
                if (k_reg == 2'd0)
                begin
                    div_req.start   = 1'b1;
                    div_req.rem     = prod_reg[PW-1:QW];
                    div_req.low     = prod_reg[QW-1:0];
                    div_req.divisor = w_reg;
                    k_next          = 2'd1;
                end
                else if (div_rsp.done)
                begin
                    add_next   = div_rsp.quot;
                    state_next = ST_N_ACC;
                end
            end
            ST_N_ACC:
            begin
                sum_next = sum_wide[FW] ? FLUX_MAX : sum_wide[FW-1:0];
                if (n_last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    n_next     = n_reg + 1'b1;
                    state_next = ST_N_RD;
                end
            end
            ST_EMIT:
            begin
                if (m_free)
                begin
                    ov_next    = 1'b1;
                    oidx_next  = OIW'(m_reg);
                    oflux_next = sum_reg;
                    olast_next = m_last;
                    if (m_last)
                    begin
                        cnt_next   = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        m_next     = m_reg + 1'b1;
                        state_next = ST_M_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            scale_reg <= S_RESET;
            half_reg  <= H_RESET;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            scale_reg <= scale_next;
            half_reg  <= half_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        i_reg     <= i_next;
        m_reg     <= m_next;
        n_reg     <= n_next;
        up_reg    <= up_next;
        lz_reg    <= lz_next;
        uz_reg    <= uz_next;
        ln_reg    <= ln_next;
        un_reg    <= un_next;
        f_reg     <= f_next;
        flag_reg  <= flag_next;
        num_reg   <= num_next;
        w_reg     <= w_next;
        prod_reg  <= prod_next;
        k_reg     <= k_next;
        add_reg   <= add_next;
        sum_reg   <= sum_next;
        oidx_reg  <= oidx_next;
        oflux_reg <= oflux_next;
        olast_reg <= olast_next;
    end

endmodule

>>> hdl/lbrr_checker.sv
// port-level checks for the redshift rebin block, bound to the top level
// depends on log_bin_spectrum_redshift_rebin_macros.svh
`include "log_bin_spectrum_redshift_rebin_macros.svh"

module lbrr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    `LBRR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `LBRR_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
    `LBRR_ASSERT_NEXT(a_last_stalls_in, s_tvalid && s_tready && s_tlast, !s_tready)
    `LBRR_ASSERT_IMPL(a_pad_zero, m_tvalid, m_tdata[55:54] == 2'b00)

endmodule

bind log_bin_spectrum_redshift_rebin lbrr_checker u_lbrr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
